[rtl/core/i2cmbe_pkg.sv]
// Shared types, codes and constants for the I2C master bit engine.
// Used by the sequencer, the result buffer and the top level; no dependencies.
`default_nettype none

package i2cmbe_pkg;

  // Command codes carried in the opcode field.
  typedef enum logic [2:0] {
    OpStart    = 3'd0,
    OpStop     = 3'd1,
    OpWrite    = 3'd2,
    OpReadAck  = 3'd3,
    OpReadNack = 3'd4
  } opcode_e;

  // Reset value of the ticks-per-phase register.
  localparam logic [7:0] PhaseTicksReset = 8'd5;

  // Phase counts per command.
  localparam logic [4:0] StartStopPhases = 5'd3;
  localparam logic [4:0] WritePhases     = 5'd27;
  localparam logic [4:0] ReadPhases      = 5'd19;

  // Landmarks inside the write and read sequences.
  localparam logic [4:0] WrDataPhases = 5'd24;  // eight bits of three phases
  localparam logic [4:0] WrAckRelease = 5'd24;  // SDA released for the ack clock
  localparam logic [4:0] WrAckHigh    = 5'd25;  // SCL high while the ack is sampled
  localparam logic [4:0] RdDataPhases = 5'd16;  // eight bits of two phases
  localparam logic [4:0] RdAckDrive   = 5'd16;  // master drives ACK or NACK
  localparam logic [4:0] RdAckHigh    = 5'd17;
  localparam logic [1:0] WrSubLast    = 2'd2;   // last of three phases of a bit
  localparam logic [3:0] BitsPerByte  = 4'd8;

  // One input word: one tick of the bus sequencer.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } cmd_t;

  // One result word: bus levels and status after the tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

  // Number of phases making up a command.
  function automatic logic [4:0] phase_total(input logic [2:0] op);
    logic [4:0] r;
    if (op == OpWrite) begin
      r = WritePhases;
    end else if (op == OpReadAck || op == OpReadNack) begin
      r = ReadPhases;
    end else begin
      r = StartStopPhases;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/i2c_master_bit_engine_unit.sv]
// I2C master bit engine: every accepted word is one bus tick and yields one result word.
// Each result word is formed combinationally and registered in the result buffer.
// Throughput: one word per cycle, one sequencer step per accepted word; input is held
// off only when both result buffer entries are waiting to be taken.
// Reset (rst_ni low, asynchronous): bus idle with SCL low, SDA high and driven,
// not busy, buffer empty, ticks per phase back to 5.
`default_nettype none

module i2c_master_bit_engine_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire i2cmbe_pkg::cmd_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output i2cmbe_pkg::res_t       out_data_o
);

  logic [7:0]       phase_ticks_q;
  logic             accept;
  logic             buf_full;
  i2cmbe_pkg::res_t step_res;

  assign in_ready_o = !buf_full;
  assign accept     = in_valid_i && in_ready_o;

  // Ticks-per-phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cmbe_pkg::PhaseTicksReset;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  // Bus sequencer.
  i2cmbe_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .phase_ticks_i (phase_ticks_q),
    .cmd_i         (in_data_i),
    .res_o         (step_res)
  );

  // Result buffer.
  i2cmbe_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (step_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A completed command never reports busy in the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.done_res && out_data_o.busy_res))
    else $error("done and busy reported together");

  // An accepted word always leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  // Input is held off only while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty result buffer");

  // A done pulse never appears in two consecutive results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step_res.done_res) |=> !(accept && step_res.done_res))
    else $error("done pulse longer than one tick");

endmodule

`default_nettype wire

[rtl/core/i2cmbe_seq.sv]
// Phase sequencer of the I2C master bit engine: holds the bus state and
// advances it by one tick per accepted word. Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        phase_ticks_i,
  input  wire i2cmbe_pkg::cmd_t  cmd_i,
  output i2cmbe_pkg::res_t       res_o
);

  // Bus line levels held between phases.
  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
  } lvl_t;

  // Levels that the start of a phase sets; anything not named is held.
  function automatic lvl_t set_lvl(input logic [2:0] op, input logic [4:0] p,
                                   input logic [1:0] sub, input logic msb,
                                   input lvl_t cur);
    lvl_t r;
    r = cur;
    if (op == i2cmbe_pkg::OpStart) begin
      r.drive = 1'b1;
      if (p == 5'd0) begin
        r.scl = 1'b1;
        r.sda = 1'b1;
      end else if (p == 5'd1) begin
        r.sda = 1'b0;
      end else begin
        r.scl = 1'b0;
      end
    end else if (op == i2cmbe_pkg::OpStop) begin
      r.drive = 1'b1;
      if (p == 5'd0) begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end else if (p == 5'd1) begin
        r.scl = 1'b1;
      end else begin
        r.sda = 1'b1;
      end
    end else if (op == i2cmbe_pkg::OpWrite) begin
      if (p < i2cmbe_pkg::WrDataPhases) begin
        r.drive = 1'b1;
        if (sub == 2'd0) begin
          r.scl = 1'b0;
          r.sda = msb;
        end else if (sub == 2'd1) begin
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end else if (p == i2cmbe_pkg::WrAckRelease) begin
        r.drive = 1'b0;
        r.sda   = 1'b1;
        r.scl   = 1'b0;
      end else if (p == i2cmbe_pkg::WrAckHigh) begin
        r.scl = 1'b1;
      end else begin
        r.scl = 1'b0;
      end
    end else begin
      if (p < i2cmbe_pkg::RdDataPhases) begin
        r.drive = 1'b0;
        r.sda   = 1'b1;
        r.scl   = p[0];
      end else if (p == i2cmbe_pkg::RdAckDrive) begin
        r.drive = 1'b1;
        r.scl   = 1'b0;
        r.sda   = (op == i2cmbe_pkg::OpReadNack);
      end else if (p == i2cmbe_pkg::RdAckHigh) begin
        r.scl = 1'b1;
      end else begin
        r.scl = 1'b0;
      end
    end
    return r;
  endfunction

  logic [2:0] op_q, op_d;
  logic [4:0] phase_q, phase_d;
  logic [1:0] sub_q, sub_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bit_q, bit_d;
  lvl_t       lvl_q, lvl_d;
  logic       busy_q, busy_d;
  logic       ack_q, ack_d;
  logic [7:0] rx_q, rx_d;
  logic       done;

  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic [4:0] phase_nxt;
  logic [1:0] sub_nxt;
  logic [3:0] bit_inc;
  logic       is_read;

  assign limit     = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
  assign tick_inc  = tick_q + 8'd1;
  assign phase_nxt = phase_q + 5'd1;
  assign sub_nxt   = (sub_q == i2cmbe_pkg::WrSubLast) ? 2'd0 : sub_q + 2'd1;
  assign bit_inc   = bit_q + 4'd1;
  assign is_read   = (op_q == i2cmbe_pkg::OpReadAck) || (op_q == i2cmbe_pkg::OpReadNack);

  // Next state for one tick: command launch when idle, phase timing when busy.
  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    lvl_d   = lvl_q;
    busy_d  = busy_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    if (!busy_q) begin
      if (cmd_i.cmd_valid && (cmd_i.opcode <= i2cmbe_pkg::OpReadNack)) begin
        op_d    = cmd_i.opcode;
        phase_d = 5'd0;
        sub_d   = 2'd0;
        tick_d  = 8'd0;
        bit_d   = 4'd0;
        shift_d = (cmd_i.opcode == i2cmbe_pkg::OpWrite) ? cmd_i.tx_byte : 8'd0;
        busy_d  = 1'b1;
        lvl_d   = set_lvl(cmd_i.opcode, 5'd0, 2'd0, shift_d[7], lvl_q);
      end
    end else begin
      tick_d = tick_inc;
      if (tick_inc >= limit) begin
        tick_d = 8'd0;
        // Work done as the current phase ends: shift a bit or take the ack.
        if (op_q == i2cmbe_pkg::OpWrite) begin
          if ((phase_q < i2cmbe_pkg::WrDataPhases) && (sub_q == i2cmbe_pkg::WrSubLast)) begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_inc;
          end else if (phase_q == i2cmbe_pkg::WrAckHigh) begin
            ack_d = cmd_i.sda_sample;
          end
        end else if (is_read) begin
          if ((phase_q < i2cmbe_pkg::RdDataPhases) && phase_q[0]) begin
            shift_d = {shift_q[6:0], cmd_i.sda_sample};
            bit_d   = bit_inc;
            if (bit_inc == i2cmbe_pkg::BitsPerByte) begin
              rx_d = shift_d;
            end
          end
        end
        // Move to the next phase or finish the command.
        if (phase_nxt >= i2cmbe_pkg::phase_total(op_q)) begin
          busy_d  = 1'b0;
          done    = 1'b1;
          phase_d = 5'd0;
        end else begin
          phase_d = phase_nxt;
          sub_d   = sub_nxt;
          lvl_d   = set_lvl(op_q, phase_nxt, sub_nxt, shift_d[7], lvl_q);
        end
      end
    end
  end

  // Result word for this tick, taken from the next state.
  always_comb begin
    res_o.scl_level   = lvl_d.scl;
    res_o.sda_level   = lvl_d.sda;
    res_o.sda_drive   = lvl_d.drive;
    res_o.busy_res    = busy_d;
    res_o.done_res    = done;
    res_o.rx_byte     = rx_d;
    res_o.ack_missing = ack_d;
  end

  // State registers advance only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= 3'd0;
      phase_q <= 5'd0;
      sub_q   <= 2'd0;
      tick_q  <= 8'd0;
      shift_q <= 8'd0;
      bit_q   <= 4'd0;
      lvl_q   <= '{scl: 1'b0, sda: 1'b1, drive: 1'b1};
      busy_q  <= 1'b0;
      ack_q   <= 1'b0;
      rx_q    <= 8'd0;
    end else if (step_i) begin
      op_q    <= op_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
      lvl_q   <= lvl_d;
      busy_q  <= busy_d;
      ack_q   <= ack_d;
      rx_q    <= rx_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2cmbe_res_buf.sv]
// Two-entry result buffer of the I2C master bit engine, so that a word can be
// taken while the previous result still waits. Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_res_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire i2cmbe_pkg::res_t  push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output i2cmbe_pkg::res_t       out_data_o
);

  i2cmbe_pkg::res_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Payload storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[dv/i2cmbe_bus_checker.sv]
`timescale 1ns / 1ps
// Checker for the I2C master bit engine: watches the tick and level channels, predicts
// each level word from its own copy of the bus sequencer and compares field by field.
// Depends on i2cmbe_pkg for the word types and command codes.

module i2cmbe_bus_checker
  import i2cmbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  cmd_t       in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  res_t       out_data_i,
  output int         fail_o,
  output int         pending_o
);

  // Predicted copy of the sequencer state and the phase length register.
  opcode_e    run_op;
  logic [4:0] phase_no;
  logic [7:0] tick_cnt;
  logic [7:0] shreg;
  logic [3:0] bits_done;
  logic       scl_q, sda_q, drv_q, busy_q, nack_q;
  logic [7:0] rx_last;
  logic [7:0] ticks_per_phase;

  // Level words predicted but not yet seen on the output.
  res_t levels_due[$];
  int   bad_cnt;

  // Number of phases in the sequence of a command.
  function automatic logic [4:0] phases_of(input opcode_e op);
    logic [4:0] n;
    case (op)
      OpWrite: n = WritePhases;
      OpReadAck, OpReadNack: n = ReadPhases;
      default: n = StartStopPhases;
    endcase
    return n;
  endfunction

  // Bus levels on entry to phase p of the running command.
  task automatic drive_phase(input logic [4:0] p);
    int sub;
    sub = p % 3;
    case (run_op)
      OpStart: begin
        drv_q = 1'b1;
        if (p == 5'd0) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
        end else if (p == 5'd1) begin
          sda_q = 1'b0;
        end else begin
          scl_q = 1'b0;
        end
      end
      OpStop: begin
        drv_q = 1'b1;
        if (p == 5'd0) begin
          scl_q = 1'b0;
          sda_q = 1'b0;
        end else if (p == 5'd1) begin
          scl_q = 1'b1;
        end else begin
          sda_q = 1'b1;
        end
      end
      OpWrite: begin
        if (p < WrDataPhases) begin
          // Each data bit: set SDA with SCL low, raise SCL, drop SCL.
          drv_q = 1'b1;
          if (sub == 0) begin
            scl_q = 1'b0;
            sda_q = shreg[7];
          end else if (sub == 1) begin
            scl_q = 1'b1;
          end else begin
            scl_q = 1'b0;
          end
        end else if (p == WrAckRelease) begin
          drv_q = 1'b0;
          sda_q = 1'b1;
          scl_q = 1'b0;
        end else if (p == WrAckHigh) begin
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      default: begin
        if (p < RdDataPhases) begin
          drv_q = 1'b0;
          sda_q = 1'b1;
          scl_q = p[0];
        end else if (p == RdAckDrive) begin
          drv_q = 1'b1;
          scl_q = 1'b0;
          sda_q = (run_op == OpReadNack);
        end else if (p == RdAckHigh) begin
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
    endcase
  endtask

  // Sampling and shifting at the last tick of phase p.
  task automatic close_phase(input logic [4:0] p, input logic sda);
    if (run_op == OpWrite) begin
      if (p < WrDataPhases && (p % 3) == 2) begin
        shreg     = shreg << 1;
        bits_done = bits_done + 4'd1;
      end else if (p == WrAckHigh) begin
        nack_q = sda;
      end
    end else if (run_op == OpReadAck || run_op == OpReadNack) begin
      if (p < RdDataPhases && p[0]) begin
        shreg     = {shreg[6:0], sda};
        bits_done = bits_done + 4'd1;
        if (bits_done == BitsPerByte) rx_last = shreg;
      end
    end
  endtask

  // One bus tick: advance the predicted sequencer and form the level word.
  task automatic bus_tick(input cmd_t w, output res_t r);
    logic [7:0] lim;
    logic       fin;
    lim = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
    fin = 1'b0;
    if (!busy_q) begin
      // Only a known command starts a sequence; anything else leaves the bus alone.
      if (w.cmd_valid && w.opcode <= OpReadNack) begin
        run_op    = opcode_e'(w.opcode);
        phase_no  = 5'd0;
        tick_cnt  = 8'd0;
        bits_done = 4'd0;
        shreg     = (run_op == OpWrite) ? w.tx_byte : 8'd0;
        busy_q    = 1'b1;
        drive_phase(5'd0);
      end
    end else begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= lim) begin
        tick_cnt = 8'd0;
        close_phase(phase_no, w.sda_sample);
        phase_no = phase_no + 5'd1;
        if (phase_no >= phases_of(run_op)) begin
          busy_q   = 1'b0;
          fin      = 1'b1;
          phase_no = 5'd0;
        end else begin
          drive_phase(phase_no);
        end
      end
    end
    r.scl_level   = scl_q;
    r.sda_level   = sda_q;
    r.sda_drive   = drv_q;
    r.busy_res    = busy_q;
    r.done_res    = fin;
    r.rx_byte     = rx_last;
    r.ack_missing = nack_q;
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
      bad_cnt++;
    end
  endtask

  // The result word is taken before the tick word of the same edge is modelled,
  // since a result word waits in a register before the block can hand it out.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t due;
    res_t got;
    if (!rst_ni) begin
      run_op          = OpStart;
      phase_no        = 5'd0;
      tick_cnt        = 8'd0;
      shreg           = 8'd0;
      bits_done       = 4'd0;
      scl_q           = 1'b0;
      sda_q           = 1'b1;
      drv_q           = 1'b1;
      busy_q          = 1'b0;
      nack_q          = 1'b0;
      rx_last         = 8'd0;
      ticks_per_phase = PhaseTicksReset;
      levels_due.delete();
    end else begin
      if (cfg_we_i) ticks_per_phase = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (levels_due.size() == 0) begin
          $display("%0t: level word %0h arrived with none expected", $time, got);
          bad_cnt++;
        end else begin
          due = levels_due.pop_front();
          check_field("scl_level", 8'(due.scl_level), 8'(got.scl_level));
          check_field("sda_level", 8'(due.sda_level), 8'(got.sda_level));
          check_field("sda_drive", 8'(due.sda_drive), 8'(got.sda_drive));
          check_field("busy_res", 8'(due.busy_res), 8'(got.busy_res));
          check_field("done_res", 8'(due.done_res), 8'(got.done_res));
          check_field("rx_byte", due.rx_byte, got.rx_byte);
          check_field("ack_missing", 8'(due.ack_missing), 8'(got.ack_missing));
        end
      end
      if (in_valid_i && in_ready_i) begin
        bus_tick(in_data_i, due);
        levels_due.push_back(due);
      end
    end
    fail_o    <= bad_cnt;
    pending_o <= levels_due.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the I2C master bit engine bench: clock, reset, tick stimulus, output stalls
// and the verdict. Needs i2cmbe_pkg, the engine and i2cmbe_bus_checker.

module testbench;
  import i2cmbe_pkg::*;

  typedef enum int {SdaLow, SdaHigh, SdaNoise} sda_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  cmd_t       in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  res_t       out_data;
  int         fails;
  int         pending;

  bit         idle_on = 1'b1;
  bit         rx_hold_req = 1'b0;
  logic [7:0] cur_ticks = PhaseTicksReset;
  int         words_sent = 0;

  i2c_master_bit_engine_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  i2cmbe_bus_checker checker_u (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_o      (fails),
    .pending_o   (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block locks up.
  initial begin
    #5_000_000;
    $display("[i2c_master_bit_engine_unit] ERROR");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request so that the
  // output buffer fills and the block pushes back on its input.
  initial begin : level_sink
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(15, 0) : 0;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic pick_sda(input sda_mode_e m);
    logic b;
    case (m)
      SdaLow:  b = 1'b0;
      SdaHigh: b = 1'b1;
      default: b = 1'($urandom_range(1, 0));
    endcase
    return b;
  endfunction

  // Offers one tick word after a random gap and waits for it to be taken.
  // Valid is only lowered when a gap really follows.
  task automatic offer_word(input cmd_t w);
    int gap;
    gap = idle_on ? $urandom_range(15, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Stops offering and waits until every predicted level word has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_phase_ticks(input logic [7:0] v);
    drain();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_ticks = v;
  endtask

  // Ticks with no command; the SDA sample is random.
  task automatic quiet_ticks(input int n);
    cmd_t w;
    repeat (n) begin
      w.cmd_valid  = 1'b0;
      w.opcode     = 3'($urandom_range(7, 0));
      w.tx_byte    = 8'($urandom);
      w.sda_sample = 1'($urandom_range(1, 0));
      offer_word(w);
    end
  endtask

  // One command followed by exactly enough ticks to see it through to done.
  // noise_pct of those ticks carry a further command that the busy block drops.
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx,
                         input sda_mode_e mode, input int noise_pct);
    cmd_t       w;
    int         span;
    logic [7:0] lim;
    lim = (cur_ticks == 8'd0) ? 8'd1 : cur_ticks;
    if (op == OpWrite) begin
      span = WritePhases * lim;
    end else if (op == OpReadAck || op == OpReadNack) begin
      span = ReadPhases * lim;
    end else if (op == OpStart || op == OpStop) begin
      span = StartStopPhases * lim;
    end else begin
      span = 0;
    end
    w.cmd_valid  = 1'b1;
    w.opcode     = op;
    w.tx_byte    = tx;
    w.sda_sample = pick_sda(mode);
    offer_word(w);
    repeat (span) begin
      w.cmd_valid  = ($urandom_range(99, 0) < noise_pct);
      w.opcode     = 3'($urandom_range(7, 0));
      w.tx_byte    = 8'($urandom);
      w.sda_sample = pick_sda(mode);
      offer_word(w);
    end
  endtask

  // A random command, mostly known ones, now and then an unknown code.
  task automatic random_cmd();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(15, 0);
    op   = (pick < 13) ? 3'(pick % 5) : 3'(pick - 8);
    run_cmd(op, 8'($urandom), sda_mode_e'($urandom_range(2, 0)), $urandom_range(20, 0));
    quiet_ticks($urandom_range(2, 0));
  endtask

  initial begin : stimulus
    logic [7:0] tick_plan [6];
    int         mark;
    bit         held;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the phase length out of reset, then each command at its extremes.
    run_cmd(OpStart, 8'h00, SdaNoise, 0);
    set_phase_ticks(8'd1);
    run_cmd(OpStart, 8'h00, SdaNoise, 0);
    run_cmd(OpWrite, 8'hFF, SdaLow, 0);
    run_cmd(OpWrite, 8'h00, SdaHigh, 0);
    run_cmd(OpWrite, 8'hA5, SdaNoise, 0);
    run_cmd(OpReadAck, 8'h00, SdaHigh, 0);
    run_cmd(OpReadNack, 8'hFF, SdaLow, 0);
    run_cmd(OpReadAck, 8'h5A, SdaNoise, 0);
    run_cmd(OpStop, 8'h00, SdaNoise, 0);
    for (int op = OpReadNack + 1; op < 8; op++) run_cmd(3'(op), 8'hFF, SdaNoise, 0);
    // Every tick of this start carries another command, all to be dropped.
    run_cmd(OpStart, 8'h00, SdaNoise, 100);
    quiet_ticks(3);

    // A zero phase length behaves as one tick per phase.
    set_phase_ticks(8'd0);
    run_cmd(OpWrite, 8'($urandom), SdaNoise, 10);
    run_cmd(OpReadNack, 8'h00, SdaNoise, 10);

    // Longer phases: kept to two short commands and run without idling.
    set_phase_ticks(8'd12);
    idle_on = 1'b0;
    run_cmd(OpStart, 8'h00, SdaNoise, 5);
    run_cmd(OpStop, 8'h00, SdaNoise, 5);
    idle_on = 1'b1;

    // Random part over several phase lengths.
    tick_plan = '{8'd2, 8'd1, 8'd3, 8'd0, 8'd1, 8'd2};
    tick_plan[4] = 8'($urandom_range(4, 1));
    foreach (tick_plan[k]) begin
      set_phase_ticks(tick_plan[k]);
      idle_on = (k != 1);
      mark = words_sent;
      held = 1'b0;
      while (words_sent < mark + 50) begin
        random_cmd();
        // Long output hold-off while the sender keeps offering words.
        if (k == 2 && !held && words_sent >= mark + 15) begin
          rx_hold_req = 1'b1;
          held = 1'b1;
        end
        // Sender pause until every result has been taken.
        if (k == 3 && !held && words_sent >= mark + 30) begin
          drain();
          held = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[i2c_master_bit_engine_unit] OK");
    end else begin
      $display("[i2c_master_bit_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/i2cmbe_pkg.sv
rtl/core/i2cmbe_seq.sv
rtl/core/i2cmbe_res_buf.sv
rtl/core/i2c_master_bit_engine_unit.sv
dv/i2cmbe_bus_checker.sv
dv/testbench.sv
